// ----- sv/hpra_pkg.sv -----
`timescale 1ns / 1ps
package hpra_pkg;
	localparam int unsigned ADDR_BITS = 48;

	typedef enum logic [3:0] {
		ST_OK         = 4'd0,
		ST_DISABLED   = 4'd1,
		ST_HINT_ALIGN = 4'd2,
		ST_SIZE_ALIGN = 4'd3,
		ST_CONFLICT   = 4'd4,
		ST_BELOW      = 4'd5,
		ST_BEYOND     = 4'd6,
		ST_CAPACITY   = 4'd7,
		ST_SLOT_INVAL = 4'd8,
		ST_BUSY       = 4'd9,
		ST_NONE_FREE  = 4'd10,
		ST_UNPLUG_MT  = 4'd11
	} status_t;

	localparam logic [2:0] REG_SPACE_BASE = 3'd0;
	localparam logic [2:0] REG_SPACE_SIZE = 3'd1;
	localparam logic [2:0] REG_ALIGN      = 3'd2;
	localparam logic [2:0] REG_LIMIT      = 3'd3;
	localparam logic [2:0] REG_SLOTS      = 3'd4;

	localparam logic OP_PLUG   = 1'b0;
	localparam logic OP_UNPLUG = 1'b1;

	typedef struct packed {
		logic          opcode;
		logic [47:0]   req_size;
		logic [47:0]   addr_hint;
		logic          slot_hint_valid;
		logic [7:0]    slot_hint;
	} req_t;

	typedef struct packed {
		logic [3:0]    status;
		logic [47:0]   assigned_addr;
		logic [4:0]    assigned_slot;
	} rsp_t;
endpackage

// ----- sv/hotplug_range_and_slot_allocator_core.sv -----
`timescale 1ns / 1ps
// Channel | Signals                      | Direction | Beat condition
// request | start, busy, req             | in        | start && !busy
// result  | done, rsp                    | out       | done (one cycle)
// config  | cfg_we, cfg_index, cfg_wdata | in        | cfg_we
// A plug walks the occupied entries in base order: n+1 passes for n occupied
// slots, each a full scan of the base/size memory through its single read
// port, then a step state; then a bounds state and the lowest-free slot
// search; done follows. An unplug passes through S_UNRD before done; an
// early reject goes straight to done. Reset clears valid bits at once. The
// receiver cannot stall; a new beat is taken in the done cycle.
module hotplug_range_and_slot_allocator_core
	import hpra_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_wdata
);
	localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int unsigned CW = $clog2(NUM_SLOTS + 2);
	localparam logic [ADDR_BITS-1:0] AMAX = '1;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_SCAN  = 8'b00000010,
		S_STEP  = 8'b00000100,
		S_BND   = 8'b00001000,
		S_SLOT  = 8'b00010000,
		S_UNRD  = 8'b00100000,
		S_UNWR  = 8'b01000000,
		S_DONE  = 8'b10000000
	} state_t;

	// config registers
	logic [47:0] space_base_q, space_size_q, limit_q;
	logic [4:0]  align_q;
	logic [5:0]  slots_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_base_q <= '0;
			space_size_q <= '0;
			align_q      <= 5'd12;
			limit_q      <= '0;
			slots_q      <= 6'd32;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPACE_BASE: space_base_q <= cfg_wdata;
				REG_SPACE_SIZE: space_size_q <= cfg_wdata;
				REG_ALIGN:      align_q      <= cfg_wdata[4:0];
				REG_LIMIT:      limit_q      <= cfg_wdata;
				REG_SLOTS:      slots_q      <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	// entry memory: base and size, one read port, registered read
	logic [95:0] mem [NUM_SLOTS];
	logic        mem_we;
	logic [SW-1:0] mem_wa, mem_ra;
	logic [95:0] mem_wd, mem_rd_q;
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		mem_rd_q <= mem[mem_ra];
	end

	logic [NUM_SLOTS-1:0] valid_q, seen_q;
	state_t      st_q;
	req_t        r_q;
	logic [63:0] addr_q;
	logic [48:0] used_q;
	logic [CW-1:0] idx_q;
	logic        rd_v_q;
	logic [SW-1:0] rd_idx_q;
	logic        best_v_q;
	logic [SW-1:0] best_q;
	logic [47:0] best_base_q, best_size_q;
	rsp_t        rsp_q;

	logic [63:0] amask;
	assign amask = (64'd1 << align_q) - 64'd1;
	logic [CW-1:0] nslots;
	assign nslots = (32'(slots_q) < NUM_SLOTS) ? CW'(slots_q) : CW'(NUM_SLOTS);

	function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	// step math on the best entry
	logic [63:0] eb, es, bend, aend, mend;
	logic ovl;
	always_comb begin
		eb   = 64'(best_base_q);
		es   = 64'(best_size_q);
		bend = sadd(eb, es);
		aend = sadd(addr_q, 64'(r_q.req_size));
		ovl  = (es != 0) && (r_q.req_size != 0) && (eb < aend) && (addr_q < bend);
		mend = sadd(bend, amask) & ~amask;
	end

	// bounds
	logic [63:0] sb, ss, sz, off;
	logic beyond;
	always_comb begin
		sb  = 64'(space_base_q);
		ss  = 64'(space_size_q);
		sz  = 64'(r_q.req_size);
		off = addr_q - sb;
		beyond = (sz > ss) || (off > ss - sz) ||
			(addr_q > 64'(AMAX)) || (sz > 64'(AMAX) - addr_q);
	end

	logic [SW-1:0] hs;
	assign hs = r_q.slot_hint[SW-1:0];
	logic hint_in;
	assign hint_in = (32'(r_q.slot_hint) < NUM_SLOTS);

	assign busy = (st_q != S_IDLE) && (st_q != S_DONE);
	assign done = (st_q == S_DONE);
	assign rsp  = rsp_q;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = hs;
		mem_wd = {r_q.req_size, addr_q[47:0]};
		mem_ra = idx_q[SW-1:0];
		if (st_q == S_IDLE || st_q == S_DONE) mem_ra = req.slot_hint[SW-1:0];
		if (st_q == S_SLOT && idx_q == nslots + CW'(1)) begin
			mem_we = 1'b1;
			mem_wa = best_q;
		end
	end

	task automatic fin(input status_t s, input logic [47:0] a, input logic [4:0] sl);
		rsp_q  <= '{status: s, assigned_addr: a, assigned_slot: sl};
		st_q   <= S_DONE;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			valid_q     <= '0;
			used_q      <= '0;
			idx_q       <= '0;
			rd_v_q      <= 1'b0;
			r_q         <= '0;
			addr_q      <= '0;
			seen_q      <= '0;
			rd_idx_q    <= '0;
			best_v_q    <= 1'b0;
			best_q      <= '0;
			best_base_q <= '0;
			best_size_q <= '0;
			rsp_q       <= '0;
		end else begin
			case (st_q)
				// done cycle also takes a new beat
				S_IDLE, S_DONE: if (start) begin
					r_q <= req;
					if (req.opcode == OP_UNPLUG) st_q <= S_UNRD;
					else if (space_size_q == 0) fin(ST_DISABLED, '0, '0);
					else if (req.addr_hint != 0 && (64'(req.addr_hint) & amask) != 0)
						fin(ST_HINT_ALIGN, '0, '0);
					else if ((64'(req.req_size) & amask) != 0)
						fin(ST_SIZE_ALIGN, '0, '0);
					else begin
						addr_q   <= (req.addr_hint != 0) ? 64'(req.addr_hint)
							: 64'(space_base_q);
						seen_q   <= '0;
						idx_q    <= '0;
						rd_v_q   <= 1'b0;
						best_v_q <= 1'b0;
						st_q     <= S_SCAN;
					end
				end else st_q <= S_IDLE;
				// unplug: memory read issued in idle
				S_UNRD: begin
					if (!hint_in || !valid_q[hs]) fin(ST_UNPLUG_MT, '0, '0);
					else begin
						valid_q[hs] <= 1'b0;
						used_q <= used_q - 49'(mem_rd_q[95:48]);
						fin(ST_OK, mem_rd_q[47:0], 5'(r_q.slot_hint));
					end
				end
				// find lowest-base unseen valid entry
				S_SCAN: begin
					rd_idx_q <= idx_q[SW-1:0];
					if (32'(idx_q) < NUM_SLOTS) idx_q <= idx_q + CW'(1);
					if (rd_v_q && valid_q[rd_idx_q] && !seen_q[rd_idx_q] &&
					    (!best_v_q || mem_rd_q[47:0] < best_base_q)) begin
						best_v_q    <= 1'b1;
						best_q      <= rd_idx_q;
						best_base_q <= mem_rd_q[47:0];
						best_size_q <= mem_rd_q[95:48];
					end
					if (rd_v_q && 32'(rd_idx_q) == NUM_SLOTS - 1) begin
						rd_v_q <= 1'b0;
						st_q   <= S_STEP;
					end else rd_v_q <= (32'(idx_q) < NUM_SLOTS);
				end
				S_STEP: begin
					if (!best_v_q) st_q <= S_BND;
					else if (ovl && r_q.addr_hint != 0) fin(ST_CONFLICT, '0, '0);
					else begin
						if (ovl) addr_q <= mend;
						seen_q[best_q] <= 1'b1;
						best_v_q <= 1'b0;
						idx_q    <= '0;
						st_q     <= S_SCAN;
					end
				end
				S_BND: begin
					if (addr_q < sb) fin(ST_BELOW, '0, '0);
					else if (beyond) fin(ST_BEYOND, '0, '0);
					else if (used_q + 49'(r_q.req_size) > 49'(limit_q))
						fin(ST_CAPACITY, '0, '0);
					else if (r_q.slot_hint_valid) begin
						if (9'(r_q.slot_hint) >= 9'(nslots)) fin(ST_SLOT_INVAL, '0, '0);
						else if (valid_q[hs]) fin(ST_BUSY, '0, '0);
						else begin
							best_q <= hs;
							idx_q  <= nslots + CW'(1);
							st_q   <= S_SLOT;
						end
					end else begin
						idx_q <= '0;
						st_q  <= S_SLOT;
					end
				end
				// lowest free slot, one per cycle; idx nslots+1 commits
				S_SLOT: begin
					if (idx_q == nslots + CW'(1)) begin
						valid_q[best_q] <= 1'b1;
						used_q <= used_q + 49'(r_q.req_size);
						fin(ST_OK, addr_q[47:0], 5'(best_q));
					end else if (idx_q == nslots) fin(ST_NONE_FREE, '0, '0);
					else if (!valid_q[idx_q[SW-1:0]]) begin
						best_q <= idx_q[SW-1:0];
						idx_q  <= nslots + CW'(1);
					end else idx_q <= idx_q + CW'(1);
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done)) else $error("beat lost");
	a_ok_used: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_OK && $past(r_q.opcode) == OP_PLUG) |->
		used_q <= 49'(limit_q)) else $error("capacity exceeded");
`endif
endmodule

// ----- tb/hpra_admission_checker.sv -----
`timescale 1ns / 1ps
// Watches the request, result and config channels, models the allocator
// and compares every result beat against the oldest predicted one.
module hpra_admission_checker
	import hpra_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  req_t        req,
	input  logic        done,
	input  rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_wdata,
	output int          errors,
	output int          pending
);
	localparam int NSLOT = 32;
	localparam logic [63:0] AMASK48 = 64'h0000_FFFF_FFFF_FFFF;

	// register mirror
	logic [63:0] win_base, win_size, cap_limit;
	logic [4:0]  align_lg;
	logic [5:0]  slot_cnt;

	// occupancy mirror
	logic        occ_valid [NSLOT];
	logic [63:0] occ_base [NSLOT];
	logic [63:0] occ_size [NSLOT];
	logic [63:0] cap_used;

	rsp_t expected_admits[$];

	function automatic rsp_t fail_rsp(logic [3:0] st);
		rsp_t r;
		r = '0;
		r.status = st;
		return r;
	endfunction

	function automatic logic spans_collide(logic [63:0] a, logic [63:0] as,
			logic [63:0] b, logic [63:0] bs);
		if (as == 0 || bs == 0)
			return 1'b0;
		return (a < b + bs) && (b < a + as);
	endfunction

	// one request against the mirrored allocator state
	function automatic rsp_t admit_predict(req_t r);
		logic [63:0] sz, hint, amask, addr, off;
		int          nsl, best, slot;
		logic        seen [NSLOT];
		rsp_t        o;
		sz = {16'd0, r.req_size};
		hint = {16'd0, r.addr_hint};
		amask = (64'd1 << align_lg) - 64'd1;
		nsl = (slot_cnt < NSLOT) ? int'(slot_cnt) : NSLOT;
		o = '0;
		if (r.opcode == OP_UNPLUG) begin
			if (r.slot_hint >= NSLOT || !occ_valid[r.slot_hint])
				return fail_rsp(ST_UNPLUG_MT);
			occ_valid[r.slot_hint] = 1'b0;
			cap_used = cap_used - occ_size[r.slot_hint];
			o.status = ST_OK;
			o.assigned_addr = occ_base[r.slot_hint][47:0];
			o.assigned_slot = r.slot_hint[4:0];
			return o;
		end
		if (win_size == 0)
			return fail_rsp(ST_DISABLED);
		if (hint != 0 && (hint & amask) != 0)
			return fail_rsp(ST_HINT_ALIGN);
		if ((sz & amask) != 0)
			return fail_rsp(ST_SIZE_ALIGN);
		addr = (hint != 0) ? hint : win_base;
		foreach (seen[i])
			seen[i] = 1'b0;
		// ascending-base walk, ties in slot order
		for (int k = 0; k < NSLOT; k++) begin
			best = -1;
			for (int i = 0; i < NSLOT; i++) begin
				if (occ_valid[i] && !seen[i] &&
				    (best < 0 || occ_base[i] < occ_base[best]))
					best = i;
			end
			if (best < 0)
				break;
			seen[best] = 1'b1;
			if (spans_collide(occ_base[best], occ_size[best], addr, sz)) begin
				if (hint != 0)
					return fail_rsp(ST_CONFLICT);
				addr = (occ_base[best] + occ_size[best] + amask) & ~amask;
			end
		end
		if (addr < win_base)
			return fail_rsp(ST_BELOW);
		off = addr - win_base;
		if (sz > win_size || off > win_size - sz ||
		    addr > AMASK48 || sz > AMASK48 - addr)
			return fail_rsp(ST_BEYOND);
		if (cap_used + sz > cap_limit)
			return fail_rsp(ST_CAPACITY);
		if (r.slot_hint_valid) begin
			if (int'(r.slot_hint) >= nsl)
				return fail_rsp(ST_SLOT_INVAL);
			if (occ_valid[r.slot_hint])
				return fail_rsp(ST_BUSY);
			slot = r.slot_hint;
		end else begin
			slot = nsl;
			for (int i = 0; i < nsl; i++) begin
				if (!occ_valid[i]) begin
					slot = i;
					break;
				end
			end
			if (slot >= nsl)
				return fail_rsp(ST_NONE_FREE);
		end
		occ_valid[slot] = 1'b1;
		occ_base[slot] = addr;
		occ_size[slot] = sz;
		cap_used = cap_used + sz;
		o.status = ST_OK;
		o.assigned_addr = addr[47:0];
		o.assigned_slot = slot[4:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			errors = 0;
			win_base = 0;
			win_size = 0;
			align_lg = 5'd12;
			cap_limit = 0;
			slot_cnt = 6'd32;
			cap_used = 0;
			foreach (occ_valid[i]) begin
				occ_valid[i] = 1'b0;
				occ_base[i] = 0;
				occ_size[i] = 0;
			end
			expected_admits.delete();
		end else begin
			// result beat: compare against oldest prediction
			if (done) begin
				if (expected_admits.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result beat: status %0d addr %h slot %0d",
							rsp.status, rsp.assigned_addr, rsp.assigned_slot);
				end else begin
					want = expected_admits.pop_front();
					if (rsp !== want) begin
						errors++;
						if (errors <= 10)
							$display({"mismatch: exp status %0d addr %h slot %0d,",
								" got status %0d addr %h slot %0d"},
								want.status, want.assigned_addr, want.assigned_slot,
								rsp.status, rsp.assigned_addr, rsp.assigned_slot);
					end
				end
			end
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_SPACE_BASE: win_base = {16'd0, cfg_wdata};
					REG_SPACE_SIZE: win_size = {16'd0, cfg_wdata};
					REG_ALIGN:      align_lg = cfg_wdata[4:0];
					REG_LIMIT:      cap_limit = {16'd0, cfg_wdata};
					REG_SLOTS:      slot_cnt = cfg_wdata[5:0];
					default: ;
				endcase
			end
			// request beat
			if (start && !busy)
				expected_admits.push_back(admit_predict(req));
		end
		pending <= expected_admits.size();
	end
endmodule

// ----- tb/hotplug_range_and_slot_allocator_core_tb.sv -----
`timescale 1ns / 1ps
module hotplug_range_and_slot_allocator_core_tb;
	import hpra_pkg::*;

	localparam longint CYCLE_LIMIT = 12_000_000;
	localparam int N_PHASES = 8;
	localparam int PHASE_ITEMS = 110;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start;
	logic        busy;
	req_t        req;
	logic        done;
	rsp_t        rsp;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_wdata;
	int          errors;
	int          pending;
	longint      cycles = 0;

	// current settings, used to shape the stimulus
	logic [47:0] cur_base;
	int          cur_align;

	always #1 clk = ~clk;

	hotplug_range_and_slot_allocator_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	hpra_admission_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .errors(errors), .pending(pending)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [47:0] rand48();
		return 48'({$urandom, $urandom});
	endfunction

	// one request beat, with a random gap in front
	task automatic issue(req_t r);
		int gap;
		gap = $urandom_range(0, 17);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
	endtask

	task automatic make_req(output req_t r, input logic op, input logic [47:0] sz,
			input logic [47:0] hint, input logic shv, input logic [7:0] sh);
		r.opcode = op;
		r.req_size = sz;
		r.addr_hint = hint;
		r.slot_hint_valid = shv;
		r.slot_hint = sh;
	endtask

	// wait until no beat is in flight
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
	endtask

	// drain, then write all registers
	task automatic set_window(logic [47:0] b, logic [47:0] sz, int al,
			logic [47:0] lim, int slots);
		drain();
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1; cfg_index <= REG_SPACE_BASE; cfg_wdata <= b;
		@(posedge clk);
		cfg_index <= REG_SPACE_SIZE; cfg_wdata <= sz;
		@(posedge clk);
		cfg_index <= REG_ALIGN; cfg_wdata <= 48'(al);
		@(posedge clk);
		cfg_index <= REG_LIMIT; cfg_wdata <= lim;
		@(posedge clk);
		cfg_index <= REG_SLOTS; cfg_wdata <= 48'(slots);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_base = b;
		cur_align = al;
	endtask

	// random beat: mostly well-formed plugs and unplugs, some noise
	task automatic random_beat();
		req_t        r;
		int          pick;
		logic [47:0] sz, hint;
		pick = $urandom_range(0, 99);
		if (pick < 38) begin
			make_req(r, OP_UNPLUG, rand48(), rand48(), 1'($urandom_range(0, 1)),
				($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, 33)));
		end else if (pick < 90) begin
			sz = 48'($urandom_range(0, 6)) << cur_align;
			hint = 48'd0;
			if ($urandom_range(0, 1))
				hint = cur_base + (48'($urandom_range(0, 40)) << cur_align);
			if ($urandom_range(0, 9) == 0)
				hint = hint | (48'd1 << $urandom_range(0, 47));
			if ($urandom_range(0, 9) == 0)
				sz = sz | (48'd1 << $urandom_range(0, 47));
			make_req(r, OP_PLUG, sz, hint, ($urandom_range(0, 9) < 3),
				8'($urandom_range(0, 35)));
		end else begin
			make_req(r, 1'($urandom), rand48(), rand48(), 1'($urandom),
				8'($urandom));
		end
		issue(r);
	endtask

	initial begin
		req_t r;
		logic [47:0] wb, ws, wl;
		int al, ns;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = REG_SPACE_BASE;
		cfg_wdata = '0;
		cur_base = '0;
		cur_align = 12;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: disabled window at reset values
		make_req(r, OP_PLUG, 48'h1000, 48'h0, 1'b0, 8'd0); issue(r);

		set_window(48'h1_0000_0000, 48'h1000_0000, 12, 48'h80_0000, 32);
		make_req(r, OP_PLUG, 48'h1000, 48'h1_0000_0800, 1'b0, 8'd0); issue(r);
		make_req(r, OP_PLUG, 48'h1800, 48'h0, 1'b0, 8'd0); issue(r);
		make_req(r, OP_PLUG, 48'h2000, 48'h0, 1'b0, 8'd0); issue(r);
		make_req(r, OP_PLUG, 48'h1000, 48'h0, 1'b0, 8'd0); issue(r);
		make_req(r, OP_PLUG, 48'h1000, 48'h1_0000_1000, 1'b0, 8'd0); issue(r);
		make_req(r, OP_PLUG, 48'h1000, 48'h1000, 1'b0, 8'd0); issue(r);
		make_req(r, OP_PLUG, 48'h2000_0000, 48'h0, 1'b0, 8'd0); issue(r);
		make_req(r, OP_PLUG, 48'h100_0000, 48'h0, 1'b0, 8'd0); issue(r);
		make_req(r, OP_PLUG, 48'h1000, 48'h0, 1'b1, 8'd40); issue(r);
		make_req(r, OP_PLUG, 48'h1000, 48'h0, 1'b1, 8'd0); issue(r);
		make_req(r, OP_PLUG, 48'h0, 48'h1_0000_0000, 1'b1, 8'd31); issue(r);
		make_req(r, OP_PLUG, 48'h1000, 48'h1_0010_0000, 1'b1, 8'd5); issue(r);
		make_req(r, OP_UNPLUG, 48'h0, 48'h0, 1'b0, 8'd0); issue(r);
		make_req(r, OP_UNPLUG, 48'h0, 48'h0, 1'b0, 8'd0); issue(r);
		make_req(r, OP_UNPLUG, 48'h0, 48'h0, 1'b1, 8'd200); issue(r);
		make_req(r, OP_UNPLUG, 48'h0, 48'h0, 1'b0, 8'd255); issue(r);
		make_req(r, OP_PLUG, '1, '1, 1'b1, '1); issue(r);

		// single slot: none free, then invalid hint
		set_window(48'h0, '1, 0, '1, 1);
		make_req(r, OP_PLUG, 48'h10, 48'h0, 1'b0, 8'd0); issue(r);
		make_req(r, OP_PLUG, 48'h10, 48'h0, 1'b0, 8'd0); issue(r);
		make_req(r, OP_PLUG, 48'h10, 48'h0, 1'b1, 8'd1); issue(r);
		make_req(r, OP_PLUG, 48'hFFFF_FFFF_FFFF, 48'h0, 1'b0, 8'd0); issue(r);

		// random phases over a spread of settings
		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: begin al = 12; ns = 32; end
				1: begin al = 0;  ns = 1;  end
				2: begin al = 30; ns = 32; end
				3: begin al = 5;  ns = 7;  end
				4: begin al = 20; ns = 16; end
				5: begin al = 12; ns = 32; end
				6: begin al = 0;  ns = 3;  end
				default: begin al = 30; ns = 32; end
			endcase
			wb = 48'($urandom_range(0, 1000)) << al;
			ws = 48'($urandom_range(16, 64)) << al;
			wl = (ph % 2 == 0) ? '1 : (48'($urandom_range(4, 40)) << al);
			if (ph == 5) begin
				wb = 48'hFFFF_FFFF_FFFF - (48'd40 << al) + 48'd1;
				ws = '1;
			end
			if (ph == 6)
				wb = 48'h0;
			set_window(wb, ws, al, wl, ns);
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_beat();
		end

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// ----- hotplug_range_and_slot_allocator_core.f -----
sv/hpra_pkg.sv
sv/hotplug_range_and_slot_allocator_core.sv
tb/hpra_admission_checker.sv
tb/hotplug_range_and_slot_allocator_core_tb.sv
